FILE: src/rar_pkg.sv
// Shared constants, codes and unit interface types for the rational arithmetic block.
package rar_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int DEN_W         = 31;
  localparam int DW            = 2 * OPERAND_WIDTH;
  localparam int DIV_CNT_W     = $clog2(DW);
  localparam int SHIFT_W       = $clog2(DW);
  localparam int IN_TDATA_W    = 4 * FIELD_W;
  localparam int OUT_BITS      = FIELD_W + DEN_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DW-1:0] MAG_LIMIT = DW'(1) << (OPERAND_WIDTH - 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDEN = 2'd1,
    STAT_OVF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_GCD_GO,
    S_GCD_WAIT,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_CHECK,
    S_FINISH
  } state_e;

  // product slots written by the multiplier, one per cycle
  typedef enum logic [1:0] {
    MSLOT_N1 = 2'd0,
    MSLOT_N2 = 2'd1,
    MSLOT_D  = 2'd2
  } mslot_e;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] res;
  } unit_rsp_t;

  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    // most negative value maps onto itself, which is its magnitude
    return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

FILE: src/rational_arith_reduce.sv
// Top level: exact fraction add/sub/mul/div with GCD reduction, sequenced over shared units.
//
// Input stream: one transaction carries the operation in s_axis_tuser and the two
// fractions in s_axis_tdata. Output stream: one transaction per input, reduced
// numerator and positive denominator in m_axis_tdata, status in m_axis_tuser
// (ok, zero denominator, overflow; on a non-ok status the data fields are zero).
// A zero result comes out as 0/1.
// One item is worked at a time; s_axis_tready is high only while the sequencer
// waits for work. The steps are three products through one 32x32 multiplier,
// one add, a binary GCD of shift/subtract steps, then two divisions by the GCD
// on one shared radix-2 divider. Zero denominators and zero results skip straight
// to the output. The result sits in an output register; the next item is taken
// while it waits, and a finished item holds in the sequencer until that register
// is free, so a stalled receiver stops the block without losing anything.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module rational_arith_reduce
  import rar_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_num, a_den, b_num, b_den (low to high)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // res_num, res_den, zero pad (low to high)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]             m_axis_tuser
);

  localparam int W = OPERAND_WIDTH;

  state_e state_q, state_d;

  logic s_hs, out_free;
  logic gcd_start, div_start;
  logic out_load;

  // operand registers
  cmd_e         cmd_q;
  logic         zden_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic         an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  mslot_e       mslot_q;

  logic [DW-1:0] p1_q, p2_q, dmag_q, nmag_q, g_q, qn_q, qd_q;
  logic          n_neg_q, d_neg_q;

  logic [FIELD_W-1:0] pend_num_q, pend_num_d;
  logic [DEN_W-1:0]   pend_den_q, pend_den_d;
  status_e            pend_stat_q, pend_stat_d;
  logic               pend_ld;

  logic               out_valid_q;
  logic [FIELD_W-1:0] res_num_q;
  logic [DEN_W-1:0]   res_den_q;
  status_e            res_stat_q;

  // input decode
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic         in_zden;

  assign in_an   = s_axis_tdata[0*FIELD_W +: W];
  assign in_ad   = s_axis_tdata[1*FIELD_W +: W];
  assign in_bn   = s_axis_tdata[2*FIELD_W +: W];
  assign in_bd   = s_axis_tdata[3*FIELD_W +: W];
  assign in_zden = (in_ad == '0) || (in_bd == '0) ||
                   ((cmd_e'(s_axis_tuser) == CMD_DIV) && (in_bn == '0));

  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // shared multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;

  always_comb begin
    case (mslot_q)
      MSLOT_N1: begin
        mul_a = an_q;
        mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      end
      MSLOT_N2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign prod = DW'(mul_a) * DW'(mul_b);

  // signed sum of the cross products
  logic          n1_neg, n2_neg, sub_neg;
  logic [DW-1:0] sum_mag;
  logic          sum_neg;

  assign n1_neg  = an_neg_q ^ ((cmd_q == CMD_MUL) ? bn_neg_q : bd_neg_q);
  assign n2_neg  = bn_neg_q ^ ad_neg_q;
  assign sub_neg = n2_neg ^ (cmd_q == CMD_SUB);

  always_comb begin
    if (cmd_q == CMD_MUL || cmd_q == CMD_DIV) begin
      sum_mag = p1_q;
      sum_neg = n1_neg;
    end else if (n1_neg == sub_neg) begin
      sum_mag = p1_q + p2_q;
      sum_neg = n1_neg;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = n1_neg;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = sub_neg;
    end
  end

  // shared units
  unit_req_t gcd_req, div_req;
  unit_rsp_t gcd_rsp, div_rsp;

  assign gcd_req.start = gcd_start;
  assign gcd_req.opa   = nmag_q;
  assign gcd_req.opb   = dmag_q;

  assign div_req.start = div_start;
  assign div_req.opa   = (state_q == S_DIVN_GO) ? nmag_q : dmag_q;
  assign div_req.opb   = g_q;

  rar_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .rsp_o  (gcd_rsp)
  );

  rar_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (s_hs) state_d = S_MUL;
      S_MUL: begin
        if (zden_q) begin
          state_d = S_FINISH;
        end else if (mslot_q == MSLOT_D) begin
          state_d = S_ADD;
        end
      end
      S_ADD:       state_d = S_GCD_GO;
      S_GCD_GO:    state_d = (nmag_q == '0) ? S_FINISH : S_GCD_WAIT;
      S_GCD_WAIT:  if (gcd_rsp.done) state_d = S_DIVN_GO;
      S_DIVN_GO:   state_d = S_DIVN_WAIT;
      S_DIVN_WAIT: if (div_rsp.done) state_d = S_DIVD_GO;
      S_DIVD_GO:   state_d = S_DIVD_WAIT;
      S_DIVD_WAIT: if (div_rsp.done) state_d = S_CHECK;
      S_CHECK:     state_d = S_FINISH;
      S_FINISH:    if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    gcd_start     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE:    s_axis_tready = 1'b1;
      S_GCD_GO:  gcd_start     = (nmag_q != '0);
      S_DIVN_GO: div_start     = 1'b1;
      S_DIVD_GO: div_start     = 1'b1;
      S_FINISH:  out_load      = out_free;
      default: begin
      end
    endcase
  end

  // pending result
  logic         res_neg, ovf;
  logic [W:0]   rn_mag, rn_signed;

  assign res_neg   = n_neg_q ^ d_neg_q;
  assign ovf       = (qd_q > MAG_LIMIT - 1'b1) ||
                     (res_neg ? (qn_q > MAG_LIMIT) : (qn_q > MAG_LIMIT - 1'b1));
  assign rn_mag    = {1'b0, qn_q[W-1:0]};
  assign rn_signed = res_neg ? (~rn_mag + 1'b1) : rn_mag;

  always_comb begin
    pend_ld     = 1'b0;
    pend_num_d  = pend_num_q;
    pend_den_d  = pend_den_q;
    pend_stat_d = pend_stat_q;
    if (state_q == S_MUL && zden_q) begin
      pend_ld     = 1'b1;
      pend_num_d  = '0;
      pend_den_d  = '0;
      pend_stat_d = STAT_ZDEN;
    end else if (state_q == S_GCD_GO && nmag_q == '0) begin
      pend_ld     = 1'b1;
      pend_num_d  = '0;
      pend_den_d  = DEN_W'(1);
      pend_stat_d = STAT_OK;
    end else if (state_q == S_CHECK) begin
      pend_ld = 1'b1;
      if (ovf) begin
        pend_num_d  = '0;
        pend_den_d  = '0;
        pend_stat_d = STAT_OVF;
      end else begin
        pend_num_d  = FIELD_W'($signed(rn_signed));
        pend_den_d  = DEN_W'(qd_q[W-2:0]);
        pend_stat_d = STAT_OK;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mslot_q     <= MSLOT_N1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_hs) begin
        mslot_q <= MSLOT_N1;
      end else if (state_q == S_MUL) begin
        mslot_q <= mslot_e'(mslot_q + 2'd1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      zden_q   <= in_zden;
      an_q     <= mag_of(in_an);
      ad_q     <= mag_of(in_ad);
      bn_q     <= mag_of(in_bn);
      bd_q     <= mag_of(in_bd);
      an_neg_q <= in_an[W-1];
      ad_neg_q <= in_ad[W-1];
      bn_neg_q <= in_bn[W-1];
      bd_neg_q <= in_bd[W-1];
    end
    if (state_q == S_MUL) begin
      case (mslot_q)
        MSLOT_N1: p1_q   <= prod;
        MSLOT_N2: p2_q   <= prod;
        default:  dmag_q <= prod;
      endcase
    end
    if (state_q == S_ADD) begin
      nmag_q  <= sum_mag;
      n_neg_q <= sum_neg;
      d_neg_q <= ad_neg_q ^ ((cmd_q == CMD_DIV) ? bn_neg_q : bd_neg_q);
    end
    if (state_q == S_GCD_WAIT && gcd_rsp.done) g_q <= gcd_rsp.res;
    if (state_q == S_DIVN_WAIT && div_rsp.done) qn_q <= div_rsp.res;
    if (state_q == S_DIVD_WAIT && div_rsp.done) qd_q <= div_rsp.res;
    if (pend_ld) begin
      pend_num_q  <= pend_num_d;
      pend_den_q  <= pend_den_d;
      pend_stat_q <= pend_stat_d;
    end
    if (out_load) begin
      res_num_q  <= pend_num_q;
      res_den_q  <= pend_den_q;
      res_stat_q <= pend_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({res_den_q, res_num_q});
  assign m_axis_tuser  = res_stat_q;

endmodule

FILE: src/rar_gcd.sv
// Binary GCD unit: one shift or subtract step per cycle on double-width magnitudes.
module rar_gcd
  import rar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DW-1:0]      x_q, x_d;
  logic [DW-1:0]      y_q, y_d;
  logic [SHIFT_W-1:0] k_q, k_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      x_d    = req_i.opa;
      y_d    = req_i.opb;
      k_d    = '0;
    end else if (busy_q) begin
      if (!x_q[0] && !y_q[0]) begin
        // common factor of two, restored at the end
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q == y_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (x_q > y_q) begin
        x_d = (x_q - y_q) >> 1;
      end else begin
        y_d = (y_q - x_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = x_q << k_q;

endmodule

FILE: src/rar_div.sv
// Restoring divider: one quotient bit per cycle, double-width unsigned operands.
module rar_div
  import rar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [DW-1:0]        quo_q, quo_d;
  logic [DW-1:0]        dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW:0]          rem_sh;
  logic                 fits;

  // remainder stays below the divisor, so the shifted value needs one extra bit only
  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = req_i.opa;
      dvs_d  = req_i.opb;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = quo_q;

endmodule

FILE: src/rar_checker.sv
// Port-level checker for the rational arithmetic block, bound to the top level.
module rar_checker
  import rar_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser
);

  // one item in flight: input side closes right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_ZDEN ||
                       m_axis_tuser == STAT_OVF))
    else $error("undefined status code");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
    else $error("error result carries nonzero data");

  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_OK |->
      m_axis_tdata[FIELD_W +: DEN_W] != '0)
    else $error("ok result with zero denominator");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);
